@@ rtl/btoram_pkg.sv @@
// Package for the binary-tree oblivious RAM controller.
// Holds the tree geometry, the sequencer state type and the command and status structs.
// No dependencies.
`default_nettype none
package btoram_pkg;

    localparam int NUM_BLOCKS   = 256;
    localparam int BUCKET_SLOTS = 16;
    localparam int DATA_WIDTH   = 64;

    localparam int DEPTH       = $clog2(NUM_BLOCKS);
    localparam int LEAVES      = 1 << DEPTH;
    localparam int NODE_W      = DEPTH + 1;
    localparam int ID_W        = $clog2(NUM_BLOCKS);
    localparam int LEAF_W      = DEPTH;
    localparam int SLOT_W      = $clog2(BUCKET_SLOTS);
    localparam int NUM_NODES   = 2 * LEAVES - 1;
    localparam int NUM_SLOTS   = NUM_NODES * BUCKET_SLOTS;
    localparam int SADDR_W     = $clog2(NUM_SLOTS);
    localparam int LEVEL_W     = $clog2(DEPTH + 1);
    localparam int LFSR_W      = 16;
    localparam int EPL_W       = 3;
    localparam int WORD_W      = 1 + ID_W + DATA_WIDTH;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [EPL_W-1:0]  EPL_RESET  = 3'd2;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd1;

    localparam logic CFG_EPL  = 1'b0;
    localparam logic CFG_SEED = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [ID_W-1:0]       id;
        logic [DATA_WIDTH-1:0] payload;
    } slot_word_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LMAP_RD, ST_LMAP_Q, ST_SC_RD, ST_SC_CHK, ST_ROOT,
        ST_PR_RD, ST_PR_CHK, ST_EV_SEL, ST_EV_RD, ST_EV_CHK, ST_EV_LMAP,
        ST_EV_LMAPQ, ST_PE_RD, ST_PE_CHK, ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic lm_rd_blk;
        logic lm_rd_id;
        logic set_scan;
        logic slot_rd;
        logic slot_next;
        logic node_up;
        logic take_hit;
        logic set_root;
        logic put;
        logic set_ovf;
        logic ev_level_up;
        logic ev_pick;
        logic ev_next;
        logic take_mover;
        logic go_child;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic slot_valid;
        logic slot_hit;
        logic slot_last;
        logic node_root;
        logic ev_done;
        logic ev_active;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/btoram_ram.sv @@
// Generic single-port RAM with a registered read.
// Width and depth are parameters; no other dependencies.
`default_nettype none
module btoram_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ rtl/btoram_ctrl.sv @@
// Sequencer for the oblivious RAM controller: scan, root placement and eviction.
// Depends on btoram_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none
module btoram_ctrl
    import btoram_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:     if (in_valid) state_next = ST_LMAP_RD;
            ST_LMAP_RD:  state_next = ST_LMAP_Q;
            ST_LMAP_Q:   state_next = ST_SC_RD;
            ST_SC_RD:    state_next = ST_SC_CHK;
            ST_SC_CHK:
            begin
                if (status.slot_hit || (status.slot_last && status.node_root))
                begin
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_ROOT:     state_next = ST_PR_RD;
            ST_PR_RD:    state_next = ST_PR_CHK;
            ST_PR_CHK:
            begin
                if (!status.slot_valid || status.slot_last)
                begin
                    state_next = ST_EV_SEL;
                end
                else
                begin
                    state_next = ST_PR_RD;
                end
            end
            ST_EV_SEL:
            begin
                if (status.ev_done)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.ev_active)
                begin
                    state_next = ST_EV_RD;
                end
            end
            ST_EV_RD:    state_next = ST_EV_CHK;
            ST_EV_CHK:
            begin
                if (status.slot_valid)
                begin
                    state_next = ST_EV_LMAP;
                end
                else if (status.slot_last)
                begin
                    state_next = ST_EV_SEL;
                end
                else
                begin
                    state_next = ST_EV_RD;
                end
            end
            ST_EV_LMAP:  state_next = ST_EV_LMAPQ;
            ST_EV_LMAPQ: state_next = ST_PE_RD;
            ST_PE_RD:    state_next = ST_PE_CHK;
            ST_PE_CHK:
            begin
                if (!status.slot_valid || status.slot_last)
                begin
                    state_next = ST_EV_SEL;
                end
                else
                begin
                    state_next = ST_PE_RD;
                end
            end
            ST_EMIT:     if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:    cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_LMAP_RD:  cmd.lm_rd_blk = 1'b1;
            ST_LMAP_Q:   cmd.set_scan = 1'b1;
            ST_SC_RD, ST_PR_RD, ST_EV_RD, ST_PE_RD: cmd.slot_rd = 1'b1;
            ST_SC_CHK:
            begin
                if (status.slot_hit)
                begin
                    cmd.take_hit = 1'b1;
                end
                else if (status.slot_last)
                begin
                    cmd.node_up = !status.node_root;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                end
            end
            ST_ROOT:     cmd.set_root = 1'b1;
            ST_PR_CHK:
            begin
                if (!status.slot_valid)
                begin
                    cmd.put = 1'b1;
                end
                else if (status.slot_last)
                begin
                    cmd.set_ovf = 1'b1;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                end
            end
            ST_EV_SEL:
            begin
                if (!status.ev_done)
                begin
                    cmd.ev_pick     = status.ev_active;
                    cmd.ev_level_up = !status.ev_active;
                end
            end
            ST_EV_CHK:
            begin
                if (status.slot_valid)
                begin
                    cmd.take_mover = 1'b1;
                end
                else if (status.slot_last)
                begin
                    cmd.ev_next = 1'b1;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                end
            end
            ST_EV_LMAP:  cmd.lm_rd_id = 1'b1;
            ST_EV_LMAPQ: cmd.go_child = 1'b1;
            ST_PE_CHK:
            begin
                if (!status.slot_valid)
                begin
                    cmd.put     = 1'b1;
                    cmd.ev_next = 1'b1;
                end
                else if (status.slot_last)
                begin
                    cmd.set_ovf = 1'b1;
                    cmd.ev_next = 1'b1;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                end
            end
            ST_EMIT:     cmd.emit = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/btoram_dp.sv @@
// Datapath of the oblivious RAM controller: slot and leaf map memories, pointers,
// eviction bucket choice, configuration registers and the result register.
// Depends on btoram_pkg and btoram_ram.
`default_nettype none
module btoram_dp
    import btoram_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic                  in_action,
    input  wire logic [ID_W-1:0]       in_block,
    input  wire logic [DATA_WIDTH-1:0] in_wdata,
    input  wire logic [7:0]            in_leaf,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_sel,
    input  wire logic [LFSR_W-1:0]     cfg_value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DATA_WIDTH-1:0]      out_rdata,
    output logic                       out_found,
    output logic                       out_ovf
);

    logic [SADDR_W-1:0]    clr_reg;
    logic                  action_reg;
    logic [ID_W-1:0]       blk_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic [LEAF_W-1:0]     nleaf_reg;
    logic [NODE_W-1:0]     node_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  found_reg;
    logic                  ovf_reg;
    logic [ID_W-1:0]       mid_reg;
    logic [DATA_WIDTH-1:0] mpl_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic [EPL_W-1:0]      k_reg;
    logic [EPL_W-1:0]      epl_reg;
    logic [LFSR_W-1:0]     lfsr_reg;
    logic                  ov_reg;
    logic [DATA_WIDTH-1:0] orda_reg;
    logic                  ofnd_reg;
    logic                  oovf_reg;

    logic                  ram_we;
    logic [SADDR_W-1:0]    ram_addr;
    slot_word_t            ram_wdata, ram_q;
    logic                  lm_we;
    logic [ID_W-1:0]       lm_addr;
    logic [LEAF_W-1:0]     lm_wdata, lm_q;
    logic [NODE_W-1:0]     node_m1;
    logic                  clr_root_slot;
    logic [NODE_W-1:0]     clr_node;
    logic [LFSR_W-1:0]     lfsr_next;
    logic [EPL_W-1:0]      k_limit;
    logic [NODE_W-1:0]     level_mask;
    logic [NODE_W-1:0]     pick_bucket;
    logic [LEVEL_W-1:0]    bit_pos;

    assign node_m1       = node_reg - NODE_W'(1);
    assign clr_node      = clr_reg[SADDR_W-1:SLOT_W];
    assign clr_root_slot = (clr_node >= NODE_W'(LEAVES - 1))
                           && (clr_reg[SLOT_W-1:0] == '0);

    always_comb
    begin
        ram_we    = cmd.clr_step || cmd.take_hit || cmd.take_mover || cmd.put;
        ram_addr  = cmd.clr_step ? clr_reg : {node_m1, slot_reg};
        ram_wdata = '0;
        if (cmd.clr_step)
        begin
            ram_wdata.valid = clr_root_slot;
            ram_wdata.id    = ID_W'(clr_node - NODE_W'(LEAVES - 1));
        end
        else if (cmd.put)
        begin
            ram_wdata.valid   = 1'b1;
            ram_wdata.id      = mid_reg;
            ram_wdata.payload = mpl_reg;
        end
    end

    always_comb
    begin
        lm_we    = (cmd.clr_step && (clr_reg < SADDR_W'(NUM_BLOCKS))) || cmd.set_scan;
        lm_addr  = cmd.clr_step ? clr_reg[ID_W-1:0] : (cmd.lm_rd_id ? mid_reg : blk_reg);
        lm_wdata = cmd.clr_step ? clr_reg[LEAF_W-1:0] : nleaf_reg;
    end

    btoram_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SLOTS)) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    btoram_ram #(.WIDTH(LEAF_W), .DEPTH(NUM_BLOCKS)) u_leaf_map (
        .clk   (clk),
        .we    (lm_we),
        .addr  (lm_addr),
        .wdata (lm_wdata),
        .rdata (lm_q)
    );

    assign lfsr_next   = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign level_mask  = (NODE_W'(1) << level_reg) - NODE_W'(1);
    assign pick_bucket = (level_reg < LEVEL_W'(2)) ? NODE_W'(k_reg)
                         : (lfsr_next[NODE_W-1:0] & level_mask);
    assign bit_pos     = LEVEL_W'(DEPTH - 1) - level_reg;

    always_comb
    begin
        case (level_reg)
            LEVEL_W'(0): k_limit = EPL_W'(1);
            LEVEL_W'(1): k_limit = EPL_W'(2);
            default:     k_limit = epl_reg;
        endcase
    end

    always_comb
    begin
        status.clr_last   = (clr_reg == SADDR_W'(NUM_SLOTS - 1));
        status.slot_valid = ram_q.valid;
        status.slot_hit   = ram_q.valid && (ram_q.id == blk_reg);
        status.slot_last  = (slot_reg == SLOT_W'(BUCKET_SLOTS - 1));
        status.node_root  = (node_reg == NODE_W'(1));
        status.ev_done    = (level_reg == LEVEL_W'(DEPTH));
        status.ev_active  = (k_reg < k_limit);
        status.out_free   = !ov_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            epl_reg  <= EPL_RESET;
            lfsr_reg <= SEED_RESET;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step && !status.clr_last)
            begin
                clr_reg <= clr_reg + SADDR_W'(1);
            end
            if (cfg_we && (cfg_sel == CFG_EPL))
            begin
                epl_reg <= cfg_value[EPL_W-1:0];
            end
            if (cfg_we && (cfg_sel == CFG_SEED))
            begin
                lfsr_reg <= cfg_value;
            end
            else if (cmd.ev_pick && (level_reg >= LEVEL_W'(2)))
            begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= in_action;
            blk_reg    <= in_block;
            wdata_reg  <= in_wdata;
            nleaf_reg  <= in_leaf[LEAF_W-1:0];
            rdata_reg  <= '0;
            found_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        if (cmd.set_scan)
        begin
            node_reg <= NODE_W'(LEAVES) | NODE_W'(lm_q);
            slot_reg <= '0;
        end
        if (cmd.slot_next)
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
        if (cmd.node_up)
        begin
            node_reg <= node_reg >> 1;
            slot_reg <= '0;
        end
        if (cmd.take_hit)
        begin
            found_reg <= 1'b1;
            rdata_reg <= ram_q.payload;
        end
        if (cmd.set_root)
        begin
            node_reg  <= NODE_W'(1);
            slot_reg  <= '0;
            mid_reg   <= blk_reg;
            mpl_reg   <= action_reg ? wdata_reg : rdata_reg;
            level_reg <= '0;
            k_reg     <= '0;
        end
        if (cmd.set_ovf)
        begin
            ovf_reg <= 1'b1;
        end
        if (cmd.ev_level_up)
        begin
            level_reg <= level_reg + LEVEL_W'(1);
            k_reg     <= '0;
        end
        if (cmd.ev_pick)
        begin
            node_reg <= (NODE_W'(1) << level_reg) | pick_bucket;
            slot_reg <= '0;
        end
        if (cmd.ev_next)
        begin
            k_reg <= k_reg + EPL_W'(1);
        end
        if (cmd.take_mover)
        begin
            mid_reg <= ram_q.id;
            mpl_reg <= ram_q.payload;
        end
        if (cmd.go_child)
        begin
            node_reg <= {node_reg[NODE_W-2:0], lm_q[bit_pos[$clog2(LEAF_W)-1:0]]};
            slot_reg <= '0;
        end
        if (cmd.emit)
        begin
            orda_reg <= rdata_reg;
            ofnd_reg <= found_reg;
            oovf_reg <= ovf_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_rdata = orda_reg;
    assign out_found = ofnd_reg;
    assign out_ovf   = oovf_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!ov_reg || out_ready))
        else $error("Result overwritten while still pending.");
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_addr <= SADDR_W'(NUM_SLOTS - 1)))
        else $error("Slot write beyond the tree.");
    a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !cmd.load_item)
        else $error("Item accepted during the clearing pass.");
    a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> !ram_q.valid)
        else $error("Block placed over an occupied slot.");
`endif

endmodule
`default_nettype wire

@@ rtl/binary_tree_oram_controller.sv @@
// Top level of the binary-tree oblivious RAM controller.
// Depends on btoram_pkg, btoram_ctrl and btoram_dp.
//
// Usage: an access word enters on the s_axis channel; tuser carries the action
// (0 read, 1 write) and tdata the block index, write data and new leaf. Each
// access returns one word on m_axis: tdata is the payload read, tuser the
// found and overflow flags. Configuration words on cfg_* set the eviction
// count (index 0) and the seed of the bucket choice LFSR (index 1); cfg_ready
// is always high. The user must write configuration only while the block is
// idle; the block itself does not enforce it. After reset a clearing pass,
// one slot a cycle, lays out the initial tree and leaf map; s_axis_tready
// stays low during it. Each slot visit is a read state and then a check state
// on the single slot memory port. An access visits slots in the path scan (up
// to nine buckets of 16 slots), in the root placement and in each evicted
// bucket and its child bucket, and reads the leaf map for each move. One access
// is handled at a time; s_axis_tready is high only between accesses. A stalled
// m_axis holds its word; the next access may already be accepted and waits
// before delivering its result.
`default_nettype none
module binary_tree_oram_controller
    import btoram_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // block_index[7:0], write_data[71:8], new_leaf[79:72]
    input  wire logic [0:0]  s_axis_tuser,  // action[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // read_data[63:0]
    output logic [1:0]       m_axis_tuser,  // found[0], overflow[1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    btoram_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    btoram_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_action (s_axis_tuser[0]),
        .in_block  (s_axis_tdata[7:0]),
        .in_wdata  (s_axis_tdata[71:8]),
        .in_leaf   (s_axis_tdata[79:72]),
        .cfg_we    (cfg_valid),
        .cfg_sel   (cfg_index[0]),
        .cfg_value (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rdata (m_axis_tdata),
        .out_found (m_axis_tuser[0]),
        .out_ovf   (m_axis_tuser[1])
    );

endmodule
`default_nettype wire

@@ dv/binary_tree_oram_checker.sv @@
// Checker for the binary-tree oblivious RAM controller: watches the access, result
// and configuration channels, predicts each result and compares it field by field.
// Depends on btoram_pkg.
module binary_tree_oram_checker
    import btoram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          error_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct {
        logic [DATA_WIDTH-1:0] payload;
        logic                  found;
        logic                  overflow;
    } access_result_t;

    logic                  tree_valid [NUM_SLOTS];
    logic [ID_W-1:0]       tree_id [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] tree_payload [NUM_SLOTS];
    logic [LEAF_W-1:0]     block_leaf [NUM_BLOCKS];
    logic [EPL_W-1:0]      evict_count;
    logic [LFSR_W-1:0]     bucket_lfsr;
    access_result_t        awaited_results [$];

    assign pending_count = awaited_results.size();

    function automatic bit store_in_node(int node, logic [ID_W-1:0] id,
                                         logic [DATA_WIDTH-1:0] payload);
        int base;
        base = (node - 1) * BUCKET_SLOTS;
        for (int i = 0; i < BUCKET_SLOTS; i++)
        begin
            if (!tree_valid[base + i])
            begin
                tree_valid[base + i] = 1'b1;
                tree_id[base + i] = id;
                tree_payload[base + i] = payload;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit push_down(int level, int bucket);
        int node;
        int base;
        logic [ID_W-1:0] id;
        logic [DATA_WIDTH-1:0] payload;
        int dir;
        node = (1 << level) + bucket;
        base = (node - 1) * BUCKET_SLOTS;
        for (int i = 0; i < BUCKET_SLOTS; i++)
        begin
            if (tree_valid[base + i])
            begin
                id = tree_id[base + i];
                payload = tree_payload[base + i];
                dir = (block_leaf[id] >> (DEPTH - 1 - level)) & 1;
                tree_valid[base + i] = 1'b0;
                tree_id[base + i] = '0;
                tree_payload[base + i] = '0;
                return !store_in_node(node * 2 + dir, id, payload);
            end
        end
        return 1'b0;
    endfunction

    function automatic access_result_t perform_access(logic action, logic [7:0] blk,
                                                      logic [63:0] wdata,
                                                      logic [7:0] nleaf);
        access_result_t r;
        int node;
        int base;
        int bucket;
        r.payload = '0;
        r.found = 1'b0;
        r.overflow = 1'b0;
        if (blk >= NUM_BLOCKS)
            return r;
        node = LEAVES + block_leaf[blk];
        block_leaf[blk] = nleaf[LEAF_W-1:0];
        while (node > 0 && !r.found)
        begin
            base = (node - 1) * BUCKET_SLOTS;
            for (int i = 0; i < BUCKET_SLOTS; i++)
            begin
                if (tree_valid[base + i] && tree_id[base + i] == blk)
                begin
                    r.found = 1'b1;
                    r.payload = tree_payload[base + i];
                    tree_valid[base + i] = 1'b0;
                    tree_id[base + i] = '0;
                    tree_payload[base + i] = '0;
                    break;
                end
            end
            node = node >> 1;
        end
        if (!store_in_node(1, blk, action ? wdata : r.payload))
            r.overflow = 1'b1;
        if (push_down(0, 0))
            r.overflow = 1'b1;
        for (int i = 0; i < 2; i++)
            if (push_down(1, i))
                r.overflow = 1'b1;
        for (int level = 2; level < DEPTH; level++)
        begin
            for (int k = 0; k < evict_count; k++)
            begin
                bucket_lfsr = bucket_lfsr[0] ? ((bucket_lfsr >> 1) ^ LFSR_TAPS)
                                             : (bucket_lfsr >> 1);
                bucket = bucket_lfsr & ((1 << level) - 1);
                if (push_down(level, bucket))
                    r.overflow = 1'b1;
            end
        end
        return r;
    endfunction

    initial
    begin
        error_count = 0;
        result_count = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tree_valid[i] = 1'b0;
            tree_id[i] = '0;
            tree_payload[i] = '0;
        end
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            block_leaf[i] = LEAF_W'(i);
            tree_valid[(LEAVES + i - 1) * BUCKET_SLOTS] = 1'b1;
            tree_id[(LEAVES + i - 1) * BUCKET_SLOTS] = ID_W'(i);
        end
        evict_count = EPL_RESET;
        bucket_lfsr = SEED_RESET;
    end

    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EPL)
                    evict_count = cfg_data[EPL_W-1:0];
                else
                    bucket_lfsr = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(perform_access(s_axis_tuser[0], s_axis_tdata[7:0],
                                                         s_axis_tdata[71:8],
                                                         s_axis_tdata[79:72]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    $error("result word with no access outstanding");
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_axis_tdata !== want.payload)
                    begin
                        $error("read_data: expected %h, got %h", want.payload, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want.found)
                    begin
                        $error("found: expected %b, got %b", want.found, m_axis_tuser[0]);
                        error_count++;
                    end
                    if (m_axis_tuser[1] !== want.overflow)
                    begin
                        $error("overflow: expected %b, got %b", want.overflow, m_axis_tuser[1]);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule

@@ dv/binary_tree_oram_controller_test.sv @@
// Top of the binary-tree oblivious RAM controller testbench: clock, reset, access
// and configuration stimulus, result-side stalls and the verdict.
// Depends on btoram_pkg, binary_tree_oram_controller and binary_tree_oram_checker.
module binary_tree_oram_controller_test;
    import btoram_pkg::*;

    localparam longint CYCLE_LIMIT = 10000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          error_count;
    int          pending_count;
    int          result_count;
    longint      cycle_count = 0;
    bit          calm = 1'b0;
    int          access_count = 0;
    logic [7:0]  hot_blocks [8];

    always #4 clk = ~clk;

    binary_tree_oram_controller dut (.*);

    binary_tree_oram_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("binary_tree_oram_controller test failed");
            $finish;
        end
    end

    initial
    begin
        int stall;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // The valid flag is dropped only before an idle gap or at the end of a burst,
    // so that back-to-back words never see two updates in one time step.
    task automatic send_access(logic action, logic [7:0] blk, logic [63:0] wdata,
                               logic [7:0] nleaf);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {nleaf, wdata, blk};
        s_axis_tuser <= action;
        do
            @(posedge clk);
        while (!s_axis_tready);
        access_count++;
    endtask

    task automatic write_register(logic [0:0] index, logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [7:0] blk;
        for (int n = 0; n < count; n++)
        begin
            blk = ($urandom_range(0, 2) == 0) ? 8'($urandom) : hot_blocks[$urandom_range(0, 7)];
            send_access(1'($urandom_range(0, 1)), blk, random_word(), 8'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            hot_blocks[i] = 8'($urandom);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_access(1'b0, 8'd0, '0, 8'd0);
        send_access(1'b1, 8'd0, '1, 8'd255);
        send_access(1'b0, 8'd0, '0, 8'd255);
        send_access(1'b1, 8'd255, 64'hA5A5_5A5A_F00D_CAFE, 8'd0);
        send_access(1'b0, 8'd255, '1, 8'd128);
        send_access(1'b0, 8'd255, '0, 8'd1);
        send_access(1'b1, 8'd17, 64'h8000_0000_0000_0001, 8'd17);
        send_access(1'b0, 8'd17, '0, 8'd170);
        for (int i = 0; i < 12; i++)
            send_access(1'b1, 8'd5, {$urandom, $urandom}, 8'd85);

        write_register(CFG_EPL, 16'd0);
        write_register(CFG_SEED, 16'hFFFF);
        random_phase(100);
        write_register(CFG_EPL, 16'd4);
        write_register(CFG_SEED, 16'd1);
        random_phase(100);
        write_register(CFG_EPL, 16'd7);
        write_register(CFG_SEED, 16'd0);
        random_phase(100);
        write_register(CFG_EPL, 16'($urandom_range(0, 7)));
        write_register(CFG_SEED, 16'($urandom_range(1, 65535)));
        random_phase(150);
        calm = 1'b1;
        random_phase(130);
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        $display("Sent %0d accesses over five eviction and seed settings; %0d results checked.",
                 access_count, result_count);
        if (error_count == 0 && pending_count == 0)
            $display("binary_tree_oram_controller test passed");
        else
            $display("binary_tree_oram_controller test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/btoram_pkg.sv
rtl/btoram_ram.sv
rtl/btoram_ctrl.sv
rtl/btoram_dp.sv
rtl/binary_tree_oram_controller.sv
dv/binary_tree_oram_checker.sv
dv/binary_tree_oram_controller_test.sv
